/* src/srss_pkg.sv */
// Shared types and constants for the selective-repeat segment scheduler.
// No dependencies.
package srss_pkg;

    localparam int SRSS_SEQ_SPACE    = 256;
    localparam int SRSS_MAX_SEGMENTS = 256;
    localparam int SRSS_GRP_W        = 16;

    localparam int SRSS_SEGS_W = 9;
    localparam int SRSS_SEQ_W  = 8;
    localparam int SRSS_SID_W  = 32;

    localparam logic MODE_REQ = 1'b0;
    localparam logic MODE_ACK = 1'b1;

    typedef struct packed {
        logic capture;
        logic emit;
        logic ack_clear;
        logic sel_masked;
        logic set_cursor;
        logic finish_low;
    } t_dp_cmd;

    typedef struct packed {
        logic is_ack;
        logic ack_hit;
        logic will_send;
        logic out_free;
        logic found;
    } t_dp_sts;

endpackage

/* src/srss_find_first.sv */
// Two-stage registered lowest-set-bit search over the segment bitmap.
// Depends on srss_pkg.
module srss_find_first #(
    parameter int DEPTH = srss_pkg::SRSS_SEQ_SPACE,
    parameter int IDX_W = $clog2(DEPTH)
) (
    input  logic             i_clk,
    input  logic [DEPTH-1:0] i_vec,
    output logic             o_found,
    output logic [IDX_W-1:0] o_idx
);
    import srss_pkg::*;

    localparam int GRP_W   = SRSS_GRP_W;
    localparam int NUM_GRP = (DEPTH + GRP_W - 1) / GRP_W;
    localparam int OFF_W   = $clog2(GRP_W);
    localparam int PAD_W   = NUM_GRP * GRP_W;

    logic [PAD_W-1:0]   pad;
    logic [NUM_GRP-1:0] grp_any;
    logic [NUM_GRP-1:0] r_grp_any;
    logic [OFF_W-1:0]   grp_off   [NUM_GRP];
    logic [OFF_W-1:0]   r_grp_off [NUM_GRP];
    logic               found;
    logic [IDX_W-1:0]   idx;
    logic               r_found;
    logic [IDX_W-1:0]   r_idx;

    // stage 1: per-group priority encode
    always_comb begin
        pad = PAD_W'(i_vec);
        for (int g = 0; g < NUM_GRP; g++) begin
            grp_any[g] = |pad[g*GRP_W +: GRP_W];
            grp_off[g] = '0;
            for (int b = GRP_W - 1; b >= 0; b--) begin
                if (pad[g*GRP_W + b]) begin
                    grp_off[g] = OFF_W'(b);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_grp_any <= grp_any;
        r_grp_off <= grp_off;
    end

    // stage 2: pick the lowest non-empty group
    always_comb begin
        found = |r_grp_any;
        idx   = '0;
        for (int g = NUM_GRP - 1; g >= 0; g--) begin
            if (r_grp_any[g]) begin
                idx = IDX_W'(g * GRP_W) | IDX_W'(r_grp_off[g]);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_found <= found;
        r_idx   <= idx;
    end

    assign o_found = r_found;
    assign o_idx   = r_idx;

endmodule

/* src/srss_ctrl.sv */
// Controller state machine for the segment scheduler.
// Depends on srss_pkg; drives srss_datapath through t_dp_cmd / t_dp_sts.
module srss_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_ready,
    input  srss_pkg::t_dp_sts i_sts,
    output srss_pkg::t_dp_cmd o_cmd
);
    import srss_pkg::*;

    typedef enum logic [4:0] {
        ST_IDLE   = 5'b00001,
        ST_EXEC   = 5'b00010,
        ST_LAUNCH = 5'b00100,
        ST_WAIT   = 5'b01000,
        ST_CHECK  = 5'b10000
    } t_state;

    t_state  r_state, n_state;
    logic    r_masked, n_masked;
    t_dp_cmd cmd;

    always_comb begin
        n_state  = r_state;
        n_masked = r_masked;
        cmd      = '0;
        unique case (r_state)
            ST_IDLE: begin
                if (i_valid) begin
                    cmd.capture = 1'b1;
                    n_state     = ST_EXEC;
                end
            end
            ST_EXEC: begin
                if (i_sts.is_ack) begin
                    if (i_sts.ack_hit) begin
                        cmd.ack_clear = 1'b1;
                        n_masked      = 1'b0;
                        n_state       = ST_LAUNCH;
                    end else begin
                        n_state = ST_IDLE;
                    end
                end else if (i_sts.out_free) begin
                    cmd.emit = 1'b1;
                    if (i_sts.will_send) begin
                        n_masked = 1'b1;
                        n_state  = ST_LAUNCH;
                    end else begin
                        n_state = ST_IDLE;
                    end
                end
            end
            ST_LAUNCH: begin
                cmd.sel_masked = r_masked;
                n_state        = ST_WAIT;
            end
            ST_WAIT: begin
                n_state = ST_CHECK;
            end
            ST_CHECK: begin
                if (r_masked) begin
                    if (i_sts.found) begin
                        cmd.set_cursor = 1'b1;
                        n_state        = ST_IDLE;
                    end else begin
                        // nothing above the cursor: wrap to the lowest
                        n_masked = 1'b0;
                        n_state  = ST_LAUNCH;
                    end
                end else begin
                    cmd.finish_low = 1'b1;
                    n_state        = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_masked <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_masked <= n_masked;
        end
    end

    assign o_ready = (r_state == ST_IDLE);
    assign o_cmd   = cmd;

endmodule

/* src/srss_datapath.sv */
// Datapath: bitmap, cursor, sample state, input capture and output register.
// Depends on srss_pkg and srss_find_first.
module srss_datapath #(
    parameter int DEPTH = srss_pkg::SRSS_SEQ_SPACE
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  srss_pkg::t_dp_cmd                   i_cmd,
    output srss_pkg::t_dp_sts                   o_sts,
    input  logic                                i_mode,
    input  logic                                i_new_sample_ready,
    input  logic [srss_pkg::SRSS_SEGS_W-1:0]    i_new_sample_segments,
    input  logic [srss_pkg::SRSS_SEQ_W-1:0]     i_ack_seqnum,
    input  logic [srss_pkg::SRSS_SID_W-1:0]     i_ack_frame_id,
    output logic                                o_valid,
    input  logic                                i_ready,
    output logic                                o_pkt_valid,
    output logic [srss_pkg::SRSS_SID_W-1:0]     o_frame_id,
    output logic [srss_pkg::SRSS_SEGS_W-1:0]    o_segment_count,
    output logic [srss_pkg::SRSS_SEQ_W-1:0]     o_seqnum
);
    import srss_pkg::*;

    localparam int IDX_W = $clog2(DEPTH);
    localparam int SEG_W = $clog2(DEPTH + 1);

    // captured item
    logic                   r_mode;
    logic                   r_nsr;
    logic [SRSS_SEGS_W-1:0] r_nss;
    logic [SRSS_SEQ_W-1:0]  r_ack_seq;
    logic [SRSS_SID_W-1:0]  r_ack_sid;

    // scheduler state
    logic [DEPTH-1:0]       r_map;
    logic [IDX_W-1:0]       r_cursor;
    logic [SEG_W-1:0]       r_segs;
    logic [SRSS_SID_W-1:0]  r_sid;
    logic                   r_loaded;
    logic                   r_any;

    // output register
    logic                   r_o_valid;
    logic                   r_o_pkt;
    logic [SRSS_SID_W-1:0]  r_o_sid;
    logic [SRSS_SEGS_W-1:0] r_o_cnt;
    logic [SRSS_SEQ_W-1:0]  r_o_seq;

    logic                   need_load;
    logic                   can_load;
    logic                   do_load;
    logic [SRSS_SEGS_W-1:0] segs_sat;
    logic [SRSS_SID_W-1:0]  sid_inc;
    logic                   ack_hit;
    logic [DEPTH-1:0]       gt_mask;
    logic [DEPTH-1:0]       load_mask;
    logic [DEPTH-1:0]       vec;
    logic                   ff_found;
    logic [IDX_W-1:0]       ff_idx;

    always_comb begin
        need_load = !r_loaded || !r_any;
        can_load  = r_nsr && (r_nss != '0);
        do_load   = i_cmd.emit && need_load && can_load;
        segs_sat  = (r_nss > SRSS_SEGS_W'(DEPTH)) ? SRSS_SEGS_W'(DEPTH) : r_nss;
        sid_inc   = r_sid + 1'b1;
        ack_hit   = (r_ack_sid == r_sid)
                 && ({1'b0, r_ack_seq} < SRSS_SEGS_W'(r_segs))
                 && r_map[r_ack_seq[IDX_W-1:0]];
        for (int i = 0; i < DEPTH; i++) begin
            gt_mask[i]   = IDX_W'(i) > r_cursor;
            load_mask[i] = SRSS_SEGS_W'(i) < segs_sat;
        end
        vec = i_cmd.sel_masked ? (r_map & gt_mask) : r_map;
    end

    srss_find_first #(
        .DEPTH (DEPTH),
        .IDX_W (IDX_W)
    ) u_find (
        .i_clk   (i_clk),
        .i_vec   (vec),
        .o_found (ff_found),
        .o_idx   (ff_idx)
    );

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_mode    <= i_mode;
            r_nsr     <= i_new_sample_ready;
            r_nss     <= i_new_sample_segments;
            r_ack_seq <= i_ack_seqnum;
            r_ack_sid <= i_ack_frame_id;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_map    <= '0;
            r_cursor <= '0;
            r_segs   <= '0;
            r_sid    <= '0;
            r_loaded <= 1'b0;
            r_any    <= 1'b0;
        end else begin
            if (do_load) begin
                r_map    <= load_mask;
                r_cursor <= '0;
                r_segs   <= SEG_W'(segs_sat);
                r_sid    <= sid_inc;
                r_loaded <= 1'b1;
                r_any    <= 1'b1;
            end
            if (i_cmd.ack_clear) begin
                r_map[r_ack_seq[IDX_W-1:0]] <= 1'b0;
            end
            if (i_cmd.set_cursor) begin
                r_cursor <= ff_idx;
            end
            if (i_cmd.finish_low) begin
                if (ff_found) begin
                    r_cursor <= ff_idx;
                end else if (r_mode == MODE_ACK) begin
                    r_cursor <= '0;
                end
                if (r_mode == MODE_ACK) begin
                    r_any <= ff_found;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (i_cmd.emit) begin
            r_o_valid <= 1'b1;
        end else if (i_ready) begin
            r_o_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            if (!need_load) begin
                r_o_pkt <= 1'b1;
                r_o_sid <= r_sid;
                r_o_cnt <= SRSS_SEGS_W'(r_segs);
                r_o_seq <= SRSS_SEQ_W'(r_cursor);
            end else if (can_load) begin
                r_o_pkt <= 1'b1;
                r_o_sid <= sid_inc;
                r_o_cnt <= segs_sat;
                r_o_seq <= '0;
            end else begin
                r_o_pkt <= 1'b0;
                r_o_sid <= '0;
                r_o_cnt <= '0;
                r_o_seq <= '0;
            end
        end
    end

    always_comb begin
        o_sts           = '0;
        o_sts.is_ack    = (r_mode == MODE_ACK);
        o_sts.ack_hit   = ack_hit;
        o_sts.will_send = !need_load || can_load;
        o_sts.out_free  = !r_o_valid || i_ready;
        o_sts.found     = ff_found;
    end

    assign o_valid         = r_o_valid;
    assign o_pkt_valid     = r_o_pkt;
    assign o_frame_id      = r_o_sid;
    assign o_segment_count = r_o_cnt;
    assign o_seqnum        = r_o_seq;

endmodule

/* src/selective_repeat_segment_scheduler_unit.sv */
// Top level of the selective-repeat segment scheduler (sender side).
// Depends on srss_pkg, srss_ctrl and srss_datapath.
//
//   channel   direction  handshake           payload
//   request   in         i_valid / o_ready   i_mode, i_new_sample_ready,
//                                            i_new_sample_segments, i_ack_seqnum,
//                                            i_ack_frame_id
//   packet    out        o_valid / i_ready   o_pkt_valid, o_frame_id,
//                                            o_segment_count, o_seqnum
//
// One item at a time; a stale ack or no-packet request goes execute, then idle.
// Others go execute, launch, wait, check; a request whose next unacked segment
// lies at or below the cursor searches the two-stage find-first tree once more.
// A request waits in its execute cycle while the packet register is still full.
// Reset (i_rst_n low, synchronous) clears the bitmap and all sample state.
module selective_repeat_segment_scheduler_unit #(
    parameter int MAX_SEGMENTS = srss_pkg::SRSS_MAX_SEGMENTS
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_valid,
    output logic                             o_ready,
    input  logic                             i_mode,
    input  logic                             i_new_sample_ready,
    input  logic [srss_pkg::SRSS_SEGS_W-1:0] i_new_sample_segments,
    input  logic [srss_pkg::SRSS_SEQ_W-1:0]  i_ack_seqnum,
    input  logic [srss_pkg::SRSS_SID_W-1:0]  i_ack_frame_id,
    output logic                             o_valid,
    input  logic                             i_ready,
    output logic                             o_pkt_valid,
    output logic [srss_pkg::SRSS_SID_W-1:0]  o_frame_id,
    output logic [srss_pkg::SRSS_SEGS_W-1:0] o_segment_count,
    output logic [srss_pkg::SRSS_SEQ_W-1:0]  o_seqnum
);
    import srss_pkg::*;

    localparam int DEPTH = (MAX_SEGMENTS < SRSS_SEQ_SPACE) ? MAX_SEGMENTS : SRSS_SEQ_SPACE;

    t_dp_cmd cmd;
    t_dp_sts sts;

    srss_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .i_sts   (sts),
        .o_cmd   (cmd)
    );

    srss_datapath #(
        .DEPTH (DEPTH)
    ) u_dp (
        .i_clk                 (i_clk),
        .i_rst_n               (i_rst_n),
        .i_cmd                 (cmd),
        .o_sts                 (sts),
        .i_mode                (i_mode),
        .i_new_sample_ready    (i_new_sample_ready),
        .i_new_sample_segments (i_new_sample_segments),
        .i_ack_seqnum          (i_ack_seqnum),
        .i_ack_frame_id        (i_ack_frame_id),
        .o_valid               (o_valid),
        .i_ready               (i_ready),
        .o_pkt_valid           (o_pkt_valid),
        .o_frame_id            (o_frame_id),
        .o_segment_count       (o_segment_count),
        .o_seqnum              (o_seqnum)
    );

    a_empty_pkt_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_pkt_valid) |->
            (o_frame_id == '0 && o_segment_count == '0 && o_seqnum == '0))
        else $error("no-packet item carries nonzero fields");

    a_seq_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_pkt_valid) |->
            (o_segment_count != '0 && {1'b0, o_seqnum} < o_segment_count))
        else $error("sent seqnum outside the current sample");

    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && o_ready) |=> !o_ready)
        else $error("second item taken while one is in progress");

    a_emit_needs_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.emit |-> (!o_valid || i_ready))
        else $error("packet register overwritten before it was taken");

endmodule
